FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define LDRF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a condition implies another one at the same edge.
`define LDRF_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies another one at the next edge.
`define LDRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ldrf_pkg.sv
package ldrf_pkg;

  localparam int LDRF_MAX_LEN = 4096;
  localparam int CHAR_W       = 8;
  localparam int CHAR_COUNT   = 1 << CHAR_W;
  localparam int START_W      = 12;
  localparam int LENGTH_W     = 13;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              end_of_string;
  } item_t;

  typedef struct packed {
    logic [START_W-1:0]  best_start;
    logic [LENGTH_W-1:0] best_length;
    logic                overflow;
  } result_t;

endpackage

FILE: design/ldrf_seen_mem.sv
module ldrf_seen_mem #(
  parameter int POS_W = ldrf_pkg::START_W
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ldrf_pkg::CHAR_W-1:0] wr_addr,
  input  logic [POS_W-1:0]          wr_data,
  input  logic                      rd_en,
  input  logic [ldrf_pkg::CHAR_W-1:0] rd_addr,
  output logic [POS_W-1:0]          rd_data
);
  import ldrf_pkg::*;

  logic [POS_W-1:0] mem [CHAR_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read that coincides with a write to the same entry returns the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

FILE: design/ldrf_window.sv
`include "assert_macros.svh"

module ldrf_window #(
  parameter int MAX_LEN = ldrf_pkg::LDRF_MAX_LEN,
  parameter int POS_W   = ldrf_pkg::START_W,
  parameter int CNT_W   = ldrf_pkg::LENGTH_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [ldrf_pkg::CHAR_W-1:0] character,
  input  logic                        end_of_string,
  input  logic [POS_W-1:0]            seen_pos,
  output logic                        wr_en,
  output logic [ldrf_pkg::CHAR_W-1:0] wr_addr,
  output logic [POS_W-1:0]            wr_data,
  output logic [POS_W-1:0]            res_start,
  output logic [CNT_W-1:0]            res_length,
  output logic                        res_overflow
);
  import ldrf_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_LEN);

  logic [CHAR_COUNT-1:0] seen_valid;
  logic [POS_W-1:0]      window_start;
  logic [CNT_W-1:0]      byte_position;
  logic [POS_W-1:0]      best_start;
  logic [CNT_W-1:0]      best_length;
  logic                  overflow_flag;

  logic                  in_range;
  logic                  hit;
  logic [POS_W-1:0]      window_start_next;
  logic [CNT_W-1:0]      run_len;
  logic                  better;

  always_comb begin
    in_range          = byte_position < LIMIT;
    hit               = seen_valid[character] && (seen_pos >= window_start);
    window_start_next = hit ? POS_W'(seen_pos + 1'b1) : window_start;
    run_len           = byte_position - CNT_W'(window_start_next) + CNT_W'(1);
    better            = in_range && (run_len > best_length);
    res_start         = better ? window_start_next : best_start;
    res_length        = better ? run_len : best_length;
    res_overflow      = overflow_flag || !in_range;
    wr_en             = fire && in_range;
    wr_addr           = character;
    wr_data           = byte_position[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_valid    <= '0;
      window_start  <= '0;
      byte_position <= '0;
      best_start    <= '0;
      best_length   <= '0;
      overflow_flag <= 1'b0;
    end else if (fire) begin
      if (end_of_string) begin
        seen_valid    <= '0;
        window_start  <= '0;
        byte_position <= '0;
        best_start    <= '0;
        best_length   <= '0;
        overflow_flag <= 1'b0;
      end else begin
        if (in_range) begin
          seen_valid[character] <= 1'b1;
          window_start          <= window_start_next;
          byte_position         <= byte_position + CNT_W'(1);
        end
        best_start    <= res_start;
        best_length   <= res_length;
        overflow_flag <= res_overflow;
      end
    end
  end

  `LDRF_ASSERT_ALWAYS(a_window_in_string, CNT_W'(window_start) <= byte_position, "window start is past the byte position")
  `LDRF_ASSERT_ALWAYS(a_best_fits, best_length <= byte_position, "best run is longer than the string so far")
  `LDRF_ASSERT_NEXT(a_clear_on_end, fire && end_of_string, (byte_position == '0) && (best_length == '0) && (seen_valid == '0), "string state not cleared after the final byte")

endmodule

FILE: design/longest_distinct_run_finder.sv
// A final byte's result is loaded into the result register when the byte leaves the
// input stage, and can then transfer out from that register.
// Throughput: one byte per cycle; a final byte waits in the input stage only
// while an earlier result is held in the result register under stall.
// Reset clears all control state and the per-value seen marks.
// The last-position table itself is not cleared and is read only behind its marks.
module longest_distinct_run_finder #(
  parameter int MAX_LEN = ldrf_pkg::LDRF_MAX_LEN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ldrf_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output ldrf_pkg::result_t result
);
  import ldrf_pkg::*;

  localparam int POS_W = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  item_t             s1_item;
  logic              s1_valid;
  logic              s1_fire;
  logic              accept;
  logic [POS_W-1:0]  seen_pos;
  logic              wr_en;
  logic [CHAR_W-1:0] wr_addr;
  logic [POS_W-1:0]  wr_data;
  logic [POS_W-1:0]  res_start;
  logic [CNT_W-1:0]  res_length;
  logic              res_overflow;

  assign s1_fire    = s1_valid && (!s1_item.end_of_string || !result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_fire;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

  ldrf_seen_mem #(
    .POS_W(POS_W)
  ) u_seen_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(item.character),
    .rd_data(seen_pos)
  );

  ldrf_window #(
    .MAX_LEN(MAX_LEN),
    .POS_W  (POS_W),
    .CNT_W  (CNT_W)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .fire         (s1_fire),
    .character    (s1_item.character),
    .end_of_string(s1_item.end_of_string),
    .seen_pos     (seen_pos),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .res_start    (res_start),
    .res_length   (res_length),
    .res_overflow (res_overflow)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && s1_item.end_of_string) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item.end_of_string) begin
      result.best_start  <= START_W'(res_start);
      result.best_length <= LENGTH_W'(res_length);
      result.overflow    <= res_overflow;
    end
  end

endmodule

FILE: dv/distinct_run_checker.sv
module distinct_run_checker
  import ldrf_pkg::*;
#(
  parameter int MAX_LEN = LDRF_MAX_LEN
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      mismatches,
  output int      pending,
  output int      results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  int      last_pos [CHAR_COUNT];
  bit      seen [CHAR_COUNT];
  int      win_start;
  int      next_pos;
  int      best_start_q;
  int      best_len_q;
  bit      too_long;
  result_t expected_runs [$];
  int      err_count = 0;
  int      compared = 0;

  task automatic clear_string();
    foreach (seen[i]) seen[i] = 1'b0;
    win_start    = 0;
    next_pos     = 0;
    best_start_q = 0;
    best_len_q   = 0;
    too_long     = 1'b0;
  endtask

  task automatic advance_window(input item_t it);
    int      run_len;
    result_t run;
    if (next_pos >= MAX_LEN) begin
      too_long = 1'b1;
    end else begin
      if (seen[it.character] && last_pos[it.character] >= win_start) begin
        win_start = last_pos[it.character] + 1;
      end
      last_pos[it.character] = next_pos;
      seen[it.character]     = 1'b1;
      run_len = next_pos - win_start + 1;
      if (run_len > best_len_q) begin
        best_len_q   = run_len;
        best_start_q = win_start;
      end
      next_pos++;
    end
    if (it.end_of_string) begin
      run.best_start  = best_start_q[START_W-1:0];
      run.best_length = best_len_q[LENGTH_W-1:0];
      run.overflow    = too_long;
      expected_runs.push_back(run);
      clear_string();
    end
  endtask

  task automatic compare_run(input result_t got);
    result_t want;
    if (expected_runs.size() == 0) begin
      err_count++;
      if (err_count <= 10) begin
        $display("%0t ERROR: unrequested result: start %0d length %0d overflow %0b",
                 $realtime, got.best_start, got.best_length, got.overflow);
      end
      return;
    end
    want = expected_runs.pop_front();
    compared++;
    if (got.best_start !== want.best_start || got.best_length !== want.best_length ||
        got.overflow !== want.overflow) begin
      err_count++;
      if (err_count <= 10) begin
        $display("%0t ERROR: start %0d length %0d overflow %0b, wanted %0d %0d %0b",
                 $realtime, got.best_start, got.best_length, got.overflow,
                 want.best_start, want.best_length, want.overflow);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_string();
      expected_runs.delete();
    end else begin
      if (result_valid && !result_stall) compare_run(result);
      if (item_valid && !item_stall) advance_window(item);
    end
    mismatches   <= err_count;
    pending      <= expected_runs.size();
    results_seen <= compared;
  end

endmodule

FILE: dv/testbench.sv
module testbench;
  import ldrf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 2000;
  localparam int ITEM_BUDGET = 1320;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;

  int          mismatches;
  int          pending;
  int          results_seen;
  int          bytes_sent = 0;
  int          strings_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  always #5 clk = ~clk;

  longest_distinct_run_finder dut (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result
  );

  distinct_run_checker run_check (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .mismatches, .pending, .results_seen
  );

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  result_stall <= 1'b0;
      STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
      STALL_HALF:  result_stall <= ($urandom_range(0, 1) == 0);
      default:     result_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles without a transfer.", IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_byte(input logic [7:0] c, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item       <= item_t'{character: c, end_of_string: is_last};
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    bytes_sent++;
  endtask

  task automatic send_text(input logic [7:0] text [$]);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    strings_sent++;
  endtask

  task automatic send_word(input string s);
    logic [7:0] text [$];
    foreach (s[i]) text.push_back(s[i]);
    send_text(text);
  endtask

  task automatic send_random_string();
    logic [7:0] text [$];
    logic [7:0] base;
    int         len;
    int         span;
    int         pick;
    pick = $urandom_range(0, 99);
    base = 8'($urandom_range(0, 255));
    if (pick < 82) begin
      len = $urandom_range(1, 24);
      case ($urandom_range(0, 5))
        0:       span = 1;
        1:       span = 2;
        2:       span = 3;
        3:       span = 6;
        4:       span = 16;
        default: span = 256;
      endcase
    end else if (pick < 97) begin
      len  = $urandom_range(20, 120);
      span = $urandom_range(8, 256);
    end else begin
      len  = $urandom_range(200, 400);
      span = 256;
    end
    repeat (len) text.push_back(base + 8'($urandom_range(0, span - 1)));
    send_text(text);
  endtask

  initial begin
    logic [7:0] text [$];
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    text = '{8'h00};
    send_text(text);
    text = '{8'hFF};
    send_text(text);
    send_word("abcabcbb");
    send_word("bbbbb");
    send_word("pwwkew");
    send_word("abba");
    send_word("abab");
    send_word("dvdf");

    text.delete();
    for (int i = 0; i < 300; i++) text.push_back(8'(i));
    send_text(text);
    text.delete();
    for (int i = 255; i >= 0; i--) text.push_back(8'(i));
    send_text(text);
    send_word("xyzzy");

    while (bytes_sent < ITEM_BUDGET) begin
      send_random_string();
    end
    item_valid <= 1'b0;

    // The checker's count is registered and so lags behind the last transfer.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d strings of %0d bytes in all under random sender gaps.",
             strings_sent, bytes_sent);
    $display("Checked %0d longest-run results while the receiver stalled on its own pattern.",
             results_seen);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
